>>> rtl/binary_window_zscore_detector_unit_defines.svh
// assertion macros for the binary window z-score detector
`ifndef BINARY_WINDOW_ZSCORE_DETECTOR_UNIT_DEFINES_SVH
`define BINARY_WINDOW_ZSCORE_DETECTOR_UNIT_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define BWZD_ASSERT_IMP(lbl, clk, rst, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("bwzd same-cycle check failed");
// next-cycle implication
`define BWZD_ASSERT_NXT(lbl, clk, rst, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("bwzd next-cycle check failed");
`else
`define BWZD_ASSERT_IMP(lbl, clk, rst, ant, cons)
`define BWZD_ASSERT_NXT(lbl, clk, rst, ant, cons)
`endif
`endif

>>> rtl/bwzd_pkg.sv
// shared constants, codes and types of the binary window z-score detector
package bwzd_pkg;

  // ring and window sizing
  localparam int WINDOW_MAX     = 540;
  localparam int WINDOW_SECONDS = 5400;
  localparam int PTR_W          = $clog2(WINDOW_MAX);
  localparam int CNT_W          = $clog2(WINDOW_MAX + 1);

  // field widths
  localparam int REG_W  = 16;
  localparam int IDX_W  = 2;
  localparam int FRAC_W = 16;
  localparam int PCT_W  = 15;

  // arithmetic widths
  localparam int RATE_SCALE = 25600;
  localparam int RATE_W     = CNT_W + 15;
  localparam int DIFF_W     = CNT_W + FRAC_W;
  localparam int DIV_D_W    = CNT_W + FRAC_W;
  localparam int DIV_N_W    = CNT_W + 26;
  localparam int DIV_CNT_W  = $clog2(DIV_N_W);
  localparam int DEV_W      = 28;

  // stream widths
  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 80;
  localparam int OUT_USER_W = 3;

  // register reset values
  localparam logic [REG_W-1:0] INTERVAL_RST = 16'd10;
  localparam logic [REG_W-1:0] MIN_BASE_RST = 16'd3;
  localparam logic [REG_W-1:0] THRESH_RST   = 16'd50;

  // calendar days that open the gate besides unknown
  localparam logic [REG_W-1:0] DAY_OPEN_A = 16'd20;
  localparam logic [REG_W-1:0] DAY_OPEN_B = 16'd21;

  // action codes
  localparam logic [IN_USER_W-1:0] ACT_PUSH  = 2'd0;
  localparam logic [IN_USER_W-1:0] ACT_EVAL  = 2'd1;
  localparam logic [IN_USER_W-1:0] ACT_CLEAR = 2'd2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_INTERVAL = 2'd0;
  localparam logic [IDX_W-1:0] REG_MIN_BASE = 2'd1;
  localparam logic [IDX_W-1:0] REG_THRESH   = 2'd2;

  // evaluation sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WLEN_DIV,
    ST_WLEN_WAIT,
    ST_SCAN_SETUP,
    ST_SCAN,
    ST_RATE_DIV,
    ST_RATE_WAIT,
    ST_Z_MUL,
    ST_Z_DIFF,
    ST_Z_DIV,
    ST_Z_WAIT,
    ST_DEV_MUL,
    ST_DEV_DIV,
    ST_DEV_WAIT,
    ST_OUT
  } state_t;

  // divider request and response
  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIV_N_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> rtl/bwzd_div.sv
// radix-2 restoring divider, one quotient bit per cycle
module bwzd_div
  import bwzd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_N_W-1:0]   num;
  logic [DIV_D_W-1:0]   den;
  logic [DIV_D_W-1:0]   rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DIV_D_W:0]     rem_sh;
  logic [DIV_D_W:0]     rem_new;
  logic                 sub_ok;

  // one trial subtraction
  always_comb begin
    rem_sh  = {rem, num[DIV_N_W-1]};
    sub_ok  = rem_sh >= {1'b0, den};
    rem_new = sub_ok ? (rem_sh - {1'b0, den}) : rem_sh;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
      end else if (busy && (cnt == DIV_CNT_W'(DIV_N_W - 1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath, quotient bits shift into the dividend register
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      num <= req.dividend;
      den <= req.divisor;
      rem <= '0;
      cnt <= '0;
    end else if (busy) begin
      num <= {num[DIV_N_W-2:0], sub_ok};
      rem <= rem_new[DIV_D_W-1:0];
      cnt <= cnt + 1'b1;
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = num;

endmodule

>>> rtl/binary_window_zscore_detector_unit.sv
// top level of the binary window z-score detector
//
// Items enter on the s_ stream: s_tuser carries the action (push a sample,
// evaluate the window, clear the window) and s_tdata the sample bits and the
// baseline figures. Push and clear give no result. An evaluate item gives
// one result item on the m_ stream; s_tready stays low while it is worked
// on. Evaluation reads the ring memory one sample a cycle over a window of
// w samples (w up to 540) and runs up to four serial divisions (window
// length, on rate, z score, threshold margin) on one shared divider.
// Three configuration registers are written through cfg_we/cfg_index/
// cfg_wdata; the user must write them only while the block is idle, which
// the block itself does not enforce; an index outside the list is ignored.
// Reset clears the ring pointers and fill count and loads the register
// defaults; the ring contents are not cleared. A result waits in the output
// register while m_tready is low; pushes and clears are still accepted then,
// and a further evaluate item holds in its last step until the result leaves.
module binary_window_zscore_detector_unit
  import bwzd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [REG_W-1:0]      cfg_wdata,
  // input items
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // sample_on, sample_dirty, baseline_present, baseline_median, baseline_mad,
  // baseline_count, cycle_day
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // action
  input  logic [IN_USER_W-1:0]  s_tuser,
  // result items
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // detected, rate_pct_q8, baseline_rate_q8, baseline_count_out, z_score_q8,
  // z_margin_pct
  output logic [OUT_DATA_W-1:0] m_tdata,
  // window_full, untrusted, decision_valid
  output logic [OUT_USER_W-1:0] m_tuser
);

`include "binary_window_zscore_detector_unit_defines.svh"

  // saturate a rounded magnitude to a signed 16-bit value
  function automatic logic [15:0] sat16(input logic neg, input logic [DIV_N_W-1:0] q);
    logic [15:0] r;
    if (neg) begin
      r = (q > DIV_N_W'(32768)) ? 16'h8000 : (16'd0 - q[15:0]);
    end else begin
      r = (q > DIV_N_W'(32767)) ? 16'h7fff : q[15:0];
    end
    return r;
  endfunction

  // input fields
  logic        in_on;
  logic        in_dirty;
  logic        in_present;
  logic [15:0] in_median;
  logic [15:0] in_mad;
  logic [15:0] in_count;
  logic [15:0] in_day;

  assign in_on      = s_tdata[0];
  assign in_dirty   = s_tdata[1];
  assign in_present = s_tdata[2];
  assign in_median  = s_tdata[18:3];
  assign in_mad     = s_tdata[34:19];
  assign in_count   = s_tdata[50:35];
  assign in_day     = s_tdata[66:51];

  // configuration registers
  logic [REG_W-1:0] interval;
  logic [REG_W-1:0] min_base;
  logic [REG_W-1:0] thresh_pct;

  // ring state
  logic [1:0]       sample_mem [WINDOW_MAX];
  logic [1:0]       rd_data;
  logic             rd_vld;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] fill_cnt;

  // evaluation state
  state_t           state;
  state_t           state_next;
  logic             present;
  logic [15:0]      median;
  logic [15:0]      mad;
  logic [15:0]      bcount;
  logic [15:0]      day;
  logic [CNT_W-1:0] win_len;
  logic [PTR_W-1:0] rd_addr;
  logic [CNT_W-1:0] issue_cnt;
  logic [CNT_W-1:0] on_cnt;
  logic             dirty;
  logic [DIFF_W-1:0] prod_mw;
  logic [DIV_D_W-1:0] prod_den;
  logic             diff_neg;
  logic [DIFF_W-1:0] diff_mag;
  logic [DEV_W-1:0] dev_prod;

  // result fields
  logic        res_full;
  logic        res_untrusted;
  logic        res_valid;
  logic        res_detected;
  logic [PCT_W-1:0] res_rate;
  logic [PCT_W-1:0] res_brate;
  logic [15:0] res_bcount;
  logic [15:0] res_z;
  logic [15:0] res_dev;

  // sequencer outputs
  logic     in_acc;
  logic     scan_issue;
  logic     out_load;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // helpers
  logic                 pct_small;
  logic                 gate_open;
  logic [CNT_W-1:0]     q_clamp;
  logic [CNT_W:0]       start_sum;
  logic [RATE_W-1:0]    rate_num;
  logic [21:0]          brate_full;
  logic [CNT_W+24-1:0]  z_num;
  logic signed [24:0]   z_ext;
  logic signed [24:0]   thr_ext;
  logic [15:0]          z_mag;
  logic [DEV_W-1:0]     dev_small;

  assign in_acc    = s_tvalid && s_tready;
  assign pct_small = thresh_pct <= 16'd2;
  assign gate_open = (day == '0) || (day == DAY_OPEN_A) || (day == DAY_OPEN_B);

  always_comb begin
    // window length from the divider, clamped to the ring
    if (div_rsp.quotient == '0) begin
      q_clamp = CNT_W'(1);
    end else if (div_rsp.quotient > DIV_N_W'(WINDOW_MAX)) begin
      q_clamp = CNT_W'(WINDOW_MAX);
    end else begin
      q_clamp = div_rsp.quotient[CNT_W-1:0];
    end
    // oldest sample of the window
    if ({1'b0, CNT_W'(wr_ptr)} >= {1'b0, win_len}) begin
      start_sum = {1'b0, CNT_W'(wr_ptr)} - {1'b0, win_len};
    end else begin
      start_sum = {1'b0, CNT_W'(wr_ptr)} + (CNT_W + 1)'(WINDOW_MAX) - {1'b0, win_len};
    end
    rate_num   = RATE_W'(on_cnt) * RATE_W'(RATE_SCALE) + RATE_W'(win_len >> 1);
    brate_full = 22'(median) * 22'd25 + 22'd32;
    z_num      = {diff_mag, 8'd0};
    z_ext      = {{9{res_z[15]}}, res_z};
    thr_ext    = $signed({1'b0, thresh_pct, 8'd0});
    z_mag      = res_z[15] ? (16'd0 - res_z) : res_z;
    dev_small  = (dev_prod + DEV_W'(128)) >> 8;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && (s_tuser == ACT_EVAL)) state_next = ST_WLEN_DIV;
      end
      ST_WLEN_DIV: begin
        state_next = (interval == '0) ? ST_SCAN_SETUP : ST_WLEN_WAIT;
      end
      ST_WLEN_WAIT: begin
        if (div_rsp.done) state_next = ST_SCAN_SETUP;
      end
      ST_SCAN_SETUP: begin
        state_next = (fill_cnt < win_len) ? ST_OUT : ST_SCAN;
      end
      ST_SCAN: begin
        if ((issue_cnt == win_len) && !rd_vld) state_next = ST_RATE_DIV;
      end
      ST_RATE_DIV: begin
        state_next = ST_RATE_WAIT;
      end
      ST_RATE_WAIT: begin
        if (div_rsp.done) begin
          if (dirty || !present || (bcount < min_base)) begin
            state_next = ST_OUT;
          end else begin
            state_next = ST_Z_MUL;
          end
        end
      end
      ST_Z_MUL: begin
        state_next = ST_Z_DIFF;
      end
      ST_Z_DIFF: begin
        state_next = ST_Z_DIV;
      end
      ST_Z_DIV: begin
        state_next = (mad == '0) ? ST_DEV_MUL : ST_Z_WAIT;
      end
      ST_Z_WAIT: begin
        if (div_rsp.done) state_next = ST_DEV_MUL;
      end
      ST_DEV_MUL: begin
        state_next = ST_DEV_DIV;
      end
      ST_DEV_DIV: begin
        state_next = pct_small ? ST_OUT : ST_DEV_WAIT;
      end
      ST_DEV_WAIT: begin
        if (div_rsp.done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready         = 1'b0;
    scan_issue       = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_N_W'(WINDOW_SECONDS);
    div_req.divisor  = DIV_D_W'(interval);
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_WLEN_DIV: begin
        div_req.start = interval != '0;
      end
      ST_SCAN: begin
        scan_issue = issue_cnt != win_len;
      end
      ST_RATE_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_N_W'(rate_num);
        div_req.divisor  = DIV_D_W'(win_len);
      end
      ST_Z_DIV: begin
        div_req.start    = mad != '0;
        div_req.dividend = DIV_N_W'(z_num) + DIV_N_W'(prod_den >> 1);
        div_req.divisor  = prod_den;
      end
      ST_DEV_DIV: begin
        div_req.start    = !pct_small;
        div_req.dividend = DIV_N_W'(dev_prod) + DIV_N_W'({thresh_pct, 7'd0});
        div_req.divisor  = DIV_D_W'({thresh_pct, 8'd0});
      end
      ST_OUT: begin
        out_load = !m_tvalid || m_tready;
      end
      default: begin
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      interval   <= INTERVAL_RST;
      min_base   <= MIN_BASE_RST;
      thresh_pct <= THRESH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INTERVAL: interval   <= cfg_wdata;
        REG_MIN_BASE: min_base   <= cfg_wdata;
        REG_THRESH:   thresh_pct <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // ring memory, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (in_acc && (s_tuser == ACT_PUSH)) begin
      sample_mem[wr_ptr] <= {in_dirty, in_on};
    end
    if (scan_issue) begin
      rd_data <= sample_mem[rd_addr];
    end
  end

  // ring pointers and read valid
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      fill_cnt <= '0;
      rd_vld   <= 1'b0;
    end else begin
      rd_vld <= scan_issue;
      if (in_acc && (s_tuser == ACT_PUSH)) begin
        wr_ptr <= (wr_ptr == PTR_W'(WINDOW_MAX - 1)) ? '0 : (wr_ptr + 1'b1);
        if (fill_cnt != CNT_W'(WINDOW_MAX)) fill_cnt <= fill_cnt + 1'b1;
      end else if (in_acc && (s_tuser == ACT_CLEAR)) begin
        wr_ptr   <= '0;
        fill_cnt <= '0;
      end
    end
  end

  // evaluation datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc && (s_tuser == ACT_EVAL)) begin
          present       <= in_present;
          median        <= in_median;
          mad           <= in_mad;
          bcount        <= in_count;
          day           <= in_day;
          res_full      <= 1'b0;
          res_untrusted <= 1'b0;
          res_valid     <= 1'b0;
          res_detected  <= 1'b0;
          res_rate      <= '0;
          res_brate     <= '0;
          res_bcount    <= '0;
          res_z         <= '0;
          res_dev       <= '0;
        end
      end
      ST_WLEN_DIV: begin
        if (interval == '0) win_len <= CNT_W'(1);
      end
      ST_WLEN_WAIT: begin
        if (div_rsp.done) win_len <= q_clamp;
      end
      ST_SCAN_SETUP: begin
        rd_addr   <= start_sum[PTR_W-1:0];
        issue_cnt <= '0;
        on_cnt    <= '0;
        dirty     <= 1'b0;
        if (fill_cnt >= win_len) res_full <= 1'b1;
      end
      ST_SCAN: begin
        // count on and dirty bits as the read data returns
        if (scan_issue) begin
          issue_cnt <= issue_cnt + 1'b1;
          rd_addr   <= (rd_addr == PTR_W'(WINDOW_MAX - 1)) ? '0 : (rd_addr + 1'b1);
        end
        if (rd_vld) begin
          on_cnt <= on_cnt + CNT_W'(rd_data[0]);
          dirty  <= dirty | rd_data[1];
        end
      end
      ST_RATE_WAIT: begin
        if (div_rsp.done) begin
          res_rate <= div_rsp.quotient[PCT_W-1:0];
          if (dirty) begin
            res_untrusted <= 1'b1;
          end else if (present) begin
            res_brate  <= brate_full[PCT_W+5:6];
            res_bcount <= bcount;
          end
        end
      end
      ST_Z_MUL: begin
        prod_mw  <= DIFF_W'(median) * DIFF_W'(win_len);
        prod_den <= DIV_D_W'(mad) * DIV_D_W'(win_len);
      end
      ST_Z_DIFF: begin
        diff_neg <= {on_cnt, 16'd0} < prod_mw;
        diff_mag <= ({on_cnt, 16'd0} < prod_mw) ? (prod_mw - {on_cnt, 16'd0})
                                                : ({on_cnt, 16'd0} - prod_mw);
      end
      ST_Z_DIV: begin
        // zero spread saturates by sign alone
        if (mad == '0) begin
          res_z <= (diff_mag == '0) ? 16'h0000 : (diff_neg ? 16'h8000 : 16'h7fff);
        end
      end
      ST_Z_WAIT: begin
        if (div_rsp.done) res_z <= sat16(diff_neg, div_rsp.quotient);
      end
      ST_DEV_MUL: begin
        dev_prod  <= DEV_W'(z_mag) * (pct_small ? DEV_W'(1000) : DEV_W'(2500));
        res_valid <= 1'b1;
        if (pct_small) begin
          res_detected <= ((z_ext * 25'sd10) >= 25'sd256) && gate_open;
        end else begin
          res_detected <= ((z_ext * 25'sd25) >= thr_ext) && gate_open;
        end
      end
      ST_DEV_DIV: begin
        if (pct_small) res_dev <= sat16(res_z[15], DIV_N_W'(dev_small));
      end
      ST_DEV_WAIT: begin
        if (div_rsp.done) res_dev <= sat16(res_z[15], div_rsp.quotient);
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, res_dev, res_z, res_bcount, res_brate, res_rate, res_detected};
      m_tuser <= {res_valid, res_untrusted, res_full};
    end
  end

  // shared divider
  bwzd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // checks
  `BWZD_ASSERT_IMP(a_div_start_idle, clk, rst, div_req.start, !div_rsp.busy)
  `BWZD_ASSERT_IMP(a_ring_range, clk, rst, 1'b1, (CNT_W'(wr_ptr) < CNT_W'(WINDOW_MAX)) && (fill_cnt <= CNT_W'(WINDOW_MAX)))
  `BWZD_ASSERT_IMP(a_scan_bound, clk, rst, state == ST_SCAN, issue_cnt <= win_len)
  `BWZD_ASSERT_IMP(a_result_from_seq, clk, rst, $rose(m_tvalid), $past(state == ST_OUT))
  `BWZD_ASSERT_NXT(a_ready_after_out, clk, rst, out_load, m_tvalid && s_tready)

endmodule
